@@ rtl/core/pase_pkg.sv @@
package pase_pkg;

    typedef enum logic [2:0] {
        OP_OPEN   = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_PLUS   = 3'd2,
        OP_MINUS  = 3'd3,
        OP_NUMBER = 3'd4,
        OP_END    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_LPAREN = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_SUB    = 2'd2,
        KIND_VALUE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_MISSING_OPERAND  = 3'd1,
        ST_UNMATCHED        = 3'd2,
        ST_EMPTY_PARENS     = 3'd3,
        ST_MISSING_OPERATOR = 3'd4,
        ST_BAD_EXPR         = 3'd5,
        ST_OVERFLOW         = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LAND   = 2'd1,
        S_REFILL = 2'd2
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] val;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value;
        logic               is_final;
    } t_result;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage

@@ rtl/core/pase_stack_mem.sv @@
module pase_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  pase_pkg::t_entry     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr_a,
    input  logic [AW-1:0]        i_rd_addr_b,
    output pase_pkg::t_entry     o_rd_a,
    output pase_pkg::t_entry     o_rd_b
);

    pase_pkg::t_entry r_mem [DEPTH];
    pase_pkg::t_entry r_rd_a;
    pase_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ rtl/core/pase_alu.sv @@
module pase_alu (
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic               i_sub,
    output logic signed [31:0] o_sum
);

    logic signed [32:0] w_ext;

    always_comb begin
        if (i_sub) begin
            w_ext = {i_a[31], i_a} - {i_b[31], i_b};
        end else begin
            w_ext = {i_a[31], i_a} + {i_b[31], i_b};
        end
        priority if (w_ext[32] != w_ext[31]) begin
            o_sum = w_ext[32] ? pase_pkg::Q_MIN : pase_pkg::Q_MAX;
        end else begin
            o_sum = w_ext[31:0];
        end
    end

endmodule

@@ rtl/core/pase_seq.sv @@
module pase_seq #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  logic [2:0]           i_op,
    input  logic signed [31:0]   i_num,
    input  logic                 i_out_room,
    output logic                 o_done,
    output pase_pkg::t_result    o_result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    pase_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    pase_pkg::t_status r_err, n_err;
    pase_pkg::t_entry  r_t, n_t;
    pase_pkg::t_entry  r_u, n_u;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    pase_pkg::t_entry  mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr_a;
    logic [AW-1:0]     mem_rd_addr_b;
    pase_pkg::t_entry  rd_a;
    pase_pkg::t_entry  rd_b;

    logic signed [31:0] alu_a;
    logic signed [31:0] alu_b;
    logic               alu_sub;
    logic signed [31:0] alu_sum;

    logic              push_en;
    pase_pkg::t_entry  push_data;
    logic              w_full;
    logic [AW-1:0]     w_c0;
    logic [AW-1:0]     w_cm2;
    logic [AW-1:0]     w_cm3;
    logic [AW-1:0]     w_cm4;
    logic [AW-1:0]     w_cm5;
    pase_pkg::t_status w_end_status;

    assign w_full = (r_cnt == CW'(STACK_DEPTH));
    assign w_c0   = r_cnt[AW-1:0];
    assign w_cm2  = w_c0 - AW'(2);
    assign w_cm3  = w_c0 - AW'(3);
    assign w_cm4  = w_c0 - AW'(4);
    assign w_cm5  = w_c0 - AW'(5);

    assign alu_a   = (r_state == pase_pkg::S_LAND) ? rd_b.val : r_u.val;
    assign alu_b   = (r_state == pase_pkg::S_LAND) ? r_t.val : i_num;
    assign alu_sub = (r_state == pase_pkg::S_LAND) ? (rd_a.kind == pase_pkg::KIND_SUB)
                                                   : (r_t.kind == pase_pkg::KIND_SUB);

    pase_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    pase_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_rd_en     (mem_rd_en),
        .i_rd_addr_a (mem_rd_addr_a),
        .i_rd_addr_b (mem_rd_addr_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pase_pkg::S_IDLE;
            r_cnt   <= '0;
            r_err   <= pase_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        r_u <= n_u;
    end

    always_comb begin
        priority if (r_err != pase_pkg::ST_OK) begin
            w_end_status = r_err;
        end else if (r_cnt == CW'(1) && r_t.kind == pase_pkg::KIND_VALUE) begin
            w_end_status = pase_pkg::ST_OK;
        end else begin
            w_end_status = pase_pkg::ST_BAD_EXPR;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_err         = r_err;
        n_t           = r_t;
        n_u           = r_u;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = w_c0;
        mem_wr_data   = r_t;
        mem_rd_en     = 1'b0;
        mem_rd_addr_a = w_cm3;
        mem_rd_addr_b = w_cm3;
        push_en       = 1'b0;
        push_data     = '{kind: pase_pkg::KIND_LPAREN, val: '0};
        o_done        = 1'b0;
        o_result      = '{status: r_err, value: '0, is_final: 1'b0};

        unique case (r_state)
            pase_pkg::S_IDLE: begin
                if (i_item_valid && i_out_room) begin
                    priority if (i_op == pase_pkg::OP_END) begin
                        o_done   = 1'b1;
                        o_result = '{status: w_end_status,
                                     value: (w_end_status == pase_pkg::ST_OK) ? r_t.val : '0,
                                     is_final: 1'b1};
                        n_cnt    = '0;
                        n_err    = pase_pkg::ST_OK;
                    end else if (r_err != pase_pkg::ST_OK) begin
                        o_done = 1'b1;
                    end else begin
                        o_done = 1'b1;
                        unique case (i_op)
                            pase_pkg::OP_OPEN: begin
                                push_en   = 1'b1;
                                push_data = '{kind: pase_pkg::KIND_LPAREN, val: '0};
                            end
                            pase_pkg::OP_PLUS, pase_pkg::OP_MINUS: begin
                                priority if (r_cnt == '0 || r_t.kind != pase_pkg::KIND_VALUE) begin
                                    n_err = pase_pkg::ST_MISSING_OPERAND;
                                end else begin
                                    push_en   = 1'b1;
                                    push_data = '{kind: (i_op == pase_pkg::OP_PLUS) ?
                                                        pase_pkg::KIND_ADD : pase_pkg::KIND_SUB,
                                                  val: '0};
                                end
                            end
                            pase_pkg::OP_NUMBER: begin
                                priority if (r_cnt == '0 || r_t.kind == pase_pkg::KIND_LPAREN) begin
                                    push_en   = 1'b1;
                                    push_data = '{kind: pase_pkg::KIND_VALUE, val: i_num};
                                end else if (r_t.kind == pase_pkg::KIND_VALUE) begin
                                    n_err = pase_pkg::ST_MISSING_OPERATOR;
                                end else begin
                                    mem_wr_en   = 1'b1;
                                    mem_wr_addr = w_cm2;
                                    mem_wr_data = '{kind: pase_pkg::KIND_VALUE, val: alu_sum};
                                    n_t         = '{kind: pase_pkg::KIND_VALUE, val: alu_sum};
                                    n_cnt       = r_cnt - CW'(1);
                                    if (r_cnt >= CW'(3)) begin
                                        mem_rd_en     = 1'b1;
                                        mem_rd_addr_a = w_cm3;
                                        n_state       = pase_pkg::S_REFILL;
                                    end
                                end
                            end
                            pase_pkg::OP_CLOSE: begin
                                priority if (r_cnt == '0) begin
                                    n_err = pase_pkg::ST_UNMATCHED;
                                end else if (r_t.kind == pase_pkg::KIND_LPAREN) begin
                                    n_err = pase_pkg::ST_EMPTY_PARENS;
                                end else if (r_t.kind != pase_pkg::KIND_VALUE) begin
                                    n_err = pase_pkg::ST_MISSING_OPERAND;
                                end else if (r_cnt == CW'(1) ||
                                             r_u.kind != pase_pkg::KIND_LPAREN) begin
                                    n_err = pase_pkg::ST_UNMATCHED;
                                end else if (r_cnt == CW'(2)) begin
                                    mem_wr_en   = 1'b1;
                                    mem_wr_addr = '0;
                                    mem_wr_data = r_t;
                                    n_cnt       = CW'(1);
                                end else begin
                                    o_done        = 1'b0;
                                    mem_rd_en     = 1'b1;
                                    mem_rd_addr_a = w_cm3;
                                    mem_rd_addr_b = (r_cnt >= CW'(4)) ? w_cm4 : w_cm3;
                                    n_state       = pase_pkg::S_LAND;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (push_en) begin
                            priority if (w_full) begin
                                n_err = pase_pkg::ST_OVERFLOW;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = w_c0;
                                mem_wr_data = push_data;
                                n_u         = r_t;
                                n_t         = push_data;
                                n_cnt       = r_cnt + CW'(1);
                            end
                        end
                        o_result.status = n_err;
                    end
                end
            end
            pase_pkg::S_LAND: begin
                if (i_out_room) begin
                    o_done  = 1'b1;
                    n_state = pase_pkg::S_IDLE;
                    unique case (rd_a.kind)
                        pase_pkg::KIND_LPAREN: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = w_cm2;
                            mem_wr_data = r_t;
                            n_u         = rd_a;
                            n_cnt       = r_cnt - CW'(1);
                        end
                        pase_pkg::KIND_VALUE: begin
                            n_err = pase_pkg::ST_MISSING_OPERATOR;
                            n_cnt = r_cnt - CW'(2);
                        end
                        pase_pkg::KIND_ADD, pase_pkg::KIND_SUB: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = w_cm4;
                            mem_wr_data = '{kind: pase_pkg::KIND_VALUE, val: alu_sum};
                            n_t         = '{kind: pase_pkg::KIND_VALUE, val: alu_sum};
                            n_cnt       = r_cnt - CW'(3);
                            if (r_cnt >= CW'(5)) begin
                                mem_rd_en     = 1'b1;
                                mem_rd_addr_a = w_cm5;
                                n_state       = pase_pkg::S_REFILL;
                            end
                        end
                    endcase
                    o_result.status = n_err;
                end
            end
            pase_pkg::S_REFILL: begin
                n_u     = rd_a;
                n_state = pase_pkg::S_IDLE;
            end
            default: begin
                n_state = pase_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.is_final) |=> (r_cnt == '0 && r_err == pase_pkg::ST_OK))
        else $error("end request did not clear stack and error");

    a_refill_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pase_pkg::S_REFILL) |=> (r_state == pase_pkg::S_IDLE))
        else $error("refill not followed by idle");

    a_land_top_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pase_pkg::S_LAND) |-> (r_t.kind == pase_pkg::KIND_VALUE && r_cnt >= CW'(3)))
        else $error("close landing without value on top");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != pase_pkg::ST_OK) |-> !mem_wr_en)
        else $error("stack written while error held");
`endif

endmodule

@@ rtl/core/paren_add_sub_stack_evaluator.sv @@
// Evaluates a tokenized infix expression of parentheses, plus, minus and
// Q16.16 numbers; every request gives exactly one response, the sticky
// status, and an end request gives the final value or the first error and
// clears the stack. Entries live in a STACK_DEPTH-deep synchronous memory
// with one write and two read ports, with the top two entries held in
// registers. Open paren, plus, minus, end, a number that starts an operand
// and any request under a held error are handled in the idle state alone,
// back to back while the output has room. A number that folds into a
// pending operator writes its sum at once and, when entries remain below
// the fold, refills the second-from-top register from memory before the
// next request is handled; a close paren over an outer level first reads
// the entries below the paren from memory, and also refills when it folds
// into a deeper operator with entries below it. A response passes from the
// input register to the output register once handled, and is held back
// while the output is stalled. No clearing pass is needed after reset.
module paren_add_sub_stack_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_number_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic               o_is_final
);

    logic               r_q_valid, n_q_valid;
    logic [2:0]         r_q_op;
    logic signed [31:0] r_q_num;
    logic               r_o_valid, n_o_valid;
    pase_pkg::t_result  r_o_res;

    logic               w_accept;
    logic               w_out_room;
    logic               w_done;
    pase_pkg::t_result  w_result;

    assign w_out_room = !r_o_valid || !i_stall;
    assign o_stall    = r_q_valid && !w_done;
    assign w_accept   = i_valid && !o_stall;

    pase_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_q_valid),
        .i_op         (r_q_op),
        .i_num        (r_q_num),
        .i_out_room   (w_out_room),
        .o_done       (w_done),
        .o_result     (w_result)
    );

    always_comb begin
        priority if (w_accept) begin
            n_q_valid = 1'b1;
        end else if (w_done) begin
            n_q_valid = 1'b0;
        end else begin
            n_q_valid = r_q_valid;
        end
        priority if (w_done) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_q_valid <= n_q_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_op  <= i_operation;
            r_q_num <= i_number_value;
        end
        if (w_done) begin
            r_o_res <= w_result;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_res.status;
    assign o_result_value = r_o_res.value;
    assign o_is_final     = r_o_res.is_final;

endmodule

@@ tb/sv/paren_add_sub_stack_evaluator_tb.sv @@
module paren_add_sub_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] num;
    } t_token;

    typedef struct packed {
        t_token            tok;
        logic              typed;
        pase_pkg::t_result want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_operation;
    logic signed [31:0] i_number_value;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic signed [31:0] o_result_value;
    logic               o_is_final;

    paren_add_sub_stack_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_number_value (i_number_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_is_final     (o_is_final)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // expression state of the block as predicted
    pase_pkg::t_kind    entry_kind [STACK_DEPTH];
    logic signed [31:0] entry_val  [STACK_DEPTH];
    int                 depth_used  = 0;
    pase_pkg::t_status  held_status = pase_pkg::ST_OK;

    pase_pkg::t_result expected_results[$];
    t_row              directed_rows[$];
    t_token            seq[$];

    int errors        = 0;
    int useful_tokens = 0;
    int sent_tokens   = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int status_seen [8];

    function automatic logic signed [31:0] clamp_q(longint v);
        if (v > longint'(pase_pkg::Q_MAX)) return pase_pkg::Q_MAX;
        if (v < longint'(pase_pkg::Q_MIN)) return pase_pkg::Q_MIN;
        return v[31:0];
    endfunction

    function automatic void note_error(pase_pkg::t_status s);
        if (held_status == pase_pkg::ST_OK) held_status = s;
    endfunction

    function automatic void push_entry(pase_pkg::t_kind k, logic signed [31:0] v);
        if (depth_used >= STACK_DEPTH) begin
            note_error(pase_pkg::ST_OVERFLOW);
        end else begin
            entry_kind[depth_used] = k;
            entry_val[depth_used]  = v;
            depth_used++;
        end
    endfunction

    function automatic void land_value(logic signed [31:0] v);
        pase_pkg::t_kind pending;
        longint          earlier;
        longint          later;
        if (depth_used == 0 || entry_kind[depth_used-1] == pase_pkg::KIND_LPAREN) begin
            push_entry(pase_pkg::KIND_VALUE, v);
        end else if (entry_kind[depth_used-1] == pase_pkg::KIND_ADD ||
                     entry_kind[depth_used-1] == pase_pkg::KIND_SUB) begin
            pending = entry_kind[depth_used-1];
            later   = longint'(v);
            earlier = 0;
            depth_used--;
            if (depth_used > 0) begin
                earlier = longint'(entry_val[depth_used-1]);
                depth_used--;
            end
            if (pending == pase_pkg::KIND_ADD)
                push_entry(pase_pkg::KIND_VALUE, clamp_q(earlier + later));
            else
                push_entry(pase_pkg::KIND_VALUE, clamp_q(earlier - later));
        end else begin
            note_error(pase_pkg::ST_MISSING_OPERATOR);
        end
    endfunction

    function automatic void close_group();
        logic signed [31:0] v;
        if (depth_used == 0) begin
            note_error(pase_pkg::ST_UNMATCHED);
            return;
        end
        if (entry_kind[depth_used-1] == pase_pkg::KIND_LPAREN) begin
            note_error(pase_pkg::ST_EMPTY_PARENS);
            return;
        end
        if (entry_kind[depth_used-1] != pase_pkg::KIND_VALUE) begin
            note_error(pase_pkg::ST_MISSING_OPERAND);
            return;
        end
        v = entry_val[depth_used-1];
        depth_used--;
        if (depth_used == 0 || entry_kind[depth_used-1] != pase_pkg::KIND_LPAREN) begin
            note_error(pase_pkg::ST_UNMATCHED);
            return;
        end
        depth_used--;
        land_value(v);
    endfunction

    function automatic pase_pkg::t_result eval_token(t_token t);
        pase_pkg::t_result r;
        r.status   = held_status;
        r.value    = '0;
        r.is_final = 1'b0;
        if (t.op == pase_pkg::OP_END) begin
            useful_tokens++;
            if (held_status == pase_pkg::ST_OK) begin
                if (depth_used != 1 || entry_kind[0] != pase_pkg::KIND_VALUE)
                    r.status = pase_pkg::ST_BAD_EXPR;
                else
                    r.value = entry_val[0];
            end
            r.is_final  = 1'b1;
            depth_used  = 0;
            held_status = pase_pkg::ST_OK;
            return r;
        end
        if (held_status == pase_pkg::ST_OK) begin
            if (t.op <= pase_pkg::OP_NUMBER) useful_tokens++;
            case (t.op)
                pase_pkg::OP_OPEN: push_entry(pase_pkg::KIND_LPAREN, '0);
                pase_pkg::OP_CLOSE: close_group();
                pase_pkg::OP_PLUS, pase_pkg::OP_MINUS: begin
                    if (depth_used == 0 || entry_kind[depth_used-1] != pase_pkg::KIND_VALUE)
                        note_error(pase_pkg::ST_MISSING_OPERAND);
                    else
                        push_entry(t.op == pase_pkg::OP_PLUS ? pase_pkg::KIND_ADD
                                                             : pase_pkg::KIND_SUB, '0);
                end
                pase_pkg::OP_NUMBER: land_value(t.num);
                default: ;
            endcase
        end
        r.status = held_status;
        return r;
    endfunction

    function automatic logic signed [31:0] random_q();
        case ($urandom_range(0, 5))
            0: return pase_pkg::Q_MAX;
            1: return pase_pkg::Q_MIN;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void put(logic [2:0] op, logic signed [31:0] num);
        t_token t;
        t.op  = op;
        t.num = num;
        seq.push_back(t);
    endfunction

    function automatic void gen_term(int level);
        if (level > 0 && $urandom_range(0, 2) == 0) begin
            put(pase_pkg::OP_OPEN, $urandom);
            gen_expr(level - 1);
            put(pase_pkg::OP_CLOSE, $urandom);
        end else begin
            put(pase_pkg::OP_NUMBER, random_q());
        end
    endfunction

    function automatic void gen_expr(int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++) begin
            if (i > 0)
                put($urandom_range(0, 1) ? pase_pkg::OP_PLUS : pase_pkg::OP_MINUS, $urandom);
            gen_term(level);
        end
    endfunction

    function automatic void build_sequence();
        int     kind_pick;
        int     n;
        int     idx;
        t_token t;
        seq.delete();
        kind_pick = $urandom_range(0, 99);
        if (kind_pick < 68) begin
            gen_expr($urandom_range(0, 3));
        end else if (kind_pick < 71) begin
            // nest deep, sometimes enough to fill the stack or to go past it
            n = $urandom_range(18, 23);
            for (int i = 0; i < n; i++) begin
                put(pase_pkg::OP_NUMBER, random_q());
                put($urandom_range(0, 1) ? pase_pkg::OP_PLUS : pase_pkg::OP_MINUS, $urandom);
                put(pase_pkg::OP_OPEN, $urandom);
            end
            put(pase_pkg::OP_NUMBER, random_q());
            for (int i = 0; i < n; i++) put(pase_pkg::OP_CLOSE, $urandom);
        end else if (kind_pick < 73) begin
            n = $urandom_range(60, 68);
            for (int i = 0; i < n; i++) put(pase_pkg::OP_OPEN, $urandom);
            put(pase_pkg::OP_NUMBER, random_q());
            for (int i = 0; i < n; i++) put(pase_pkg::OP_CLOSE, $urandom);
        end else if (kind_pick < 88) begin
            gen_expr($urandom_range(0, 2));
            idx = $urandom_range(0, seq.size() - 1);
            t.op  = 3'($urandom_range(0, 7));
            t.num = $urandom;
            case ($urandom_range(0, 2))
                0: begin
                    t.num = seq[idx].num;
                    seq[idx] = t;
                end
                1: seq.delete(idx);
                default: seq.insert(idx, t);
            endcase
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) put(3'($urandom_range(0, 7)), $urandom);
        end
        put(pase_pkg::OP_END, $urandom);
    endfunction

    function automatic void add_row(logic [2:0] op, logic signed [31:0] num, logic typed,
                                    pase_pkg::t_status st, logic signed [31:0] value,
                                    logic fin);
        t_row r;
        r.tok.op        = op;
        r.tok.num       = num;
        r.typed         = typed;
        r.want.status   = st;
        r.want.value    = value;
        r.want.is_final = fin;
        directed_rows.push_back(r);
    endfunction

    task automatic offer_token(t_token t, logic typed, pase_pkg::t_result want);
        pase_pkg::t_result predicted;
        int                gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid        <= 1'b0;
                i_operation    <= 3'($urandom);
                i_number_value <= $urandom;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_operation    <= t.op;
        i_number_value <= t.num;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        sent_tokens++;
        predicted = eval_token(t);
        expected_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    always @(posedge i_clk) begin
        pase_pkg::t_result head;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected response status %0d value %h final %0b",
                         $time, o_status, o_result_value, o_is_final);
                errors++;
            end else begin
                head = expected_results.pop_front();
                if (o_status !== head.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head.status, o_status);
                    errors++;
                end
                if (o_result_value !== head.value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, head.value, o_result_value);
                    errors++;
                end
                if (o_is_final !== head.is_final) begin
                    $display("%0t: is_final expected %0b actual %0b",
                             $time, head.is_final, o_is_final);
                    errors++;
                end
                if (head.is_final) status_seen[head.status]++;
            end
        end
    end

    initial begin
        int phase_no;
        int mode;
        int len;
        phase_no = 0;
        i_stall  = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            phase_no++;
            if (phase_no % 8 == 3) begin
                // hold off long enough to back up the input side
                len = $urandom_range(150, 300);
                repeat (len) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(20, 300);
                for (int k = 0; k < len; k++) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= (k % 4 == 3);
                        default: i_stall <= 1'($urandom_range(0, 1));
                    endcase
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d responses pending",
                 cycle_count, expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_row              row;
        pase_pkg::t_result none;
        none = '0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = '0;
        i_number_value = '0;

        add_row(3'd7, 32'hFFFF_FFFF, 1'b1, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_BAD_EXPR, 0, 1'b1);
        add_row(pase_pkg::OP_NUMBER, pase_pkg::Q_MAX, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_PLUS, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_NUMBER, 32'sd1, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_OK, pase_pkg::Q_MAX, 1'b1);
        add_row(pase_pkg::OP_NUMBER, pase_pkg::Q_MIN, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_MINUS, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_NUMBER, pase_pkg::Q_MAX, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_OK, pase_pkg::Q_MIN, 1'b1);
        add_row(pase_pkg::OP_PLUS, 0, 1'b1, pase_pkg::ST_MISSING_OPERAND, 0, 1'b0);
        add_row(pase_pkg::OP_NUMBER, 32'sh0005_0000, 1'b1, pase_pkg::ST_MISSING_OPERAND,
                0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_MISSING_OPERAND, 0, 1'b1);
        add_row(pase_pkg::OP_CLOSE, 0, 1'b1, pase_pkg::ST_UNMATCHED, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_UNMATCHED, 0, 1'b1);
        add_row(pase_pkg::OP_OPEN, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_CLOSE, 0, 1'b1, pase_pkg::ST_EMPTY_PARENS, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_EMPTY_PARENS, 0, 1'b1);
        add_row(pase_pkg::OP_NUMBER, 32'sh0003_0000, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_NUMBER, 32'sh0004_0000, 1'b1, pase_pkg::ST_MISSING_OPERATOR,
                0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_MISSING_OPERATOR, 0, 1'b1);
        add_row(pase_pkg::OP_NUMBER, 32'sh000A_0000, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_MINUS, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_OPEN, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_NUMBER, 32'sh0003_0000, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_CLOSE, 0, 1'b0, pase_pkg::ST_OK, 0, 1'b0);
        add_row(pase_pkg::OP_END, 0, 1'b1, pase_pkg::ST_OK, 32'sh0007_0000, 1'b1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_token(row.tok, row.typed, row.want);
        end

        while (sent_tokens < RANDOM_ITEMS) begin
            build_sequence();
            foreach (seq[i]) offer_token(seq[i], 1'b0, none);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (%0d live) in %0d cycles; ends: %0d ok, %0d bad form,",
                 sent_tokens, useful_tokens, cycle_count, status_seen[pase_pkg::ST_OK],
                 status_seen[pase_pkg::ST_BAD_EXPR]);
        $display("  %0d overflow, %0d missing operand, %0d unmatched, %0d empty parens, %0d %s",
                 status_seen[pase_pkg::ST_OVERFLOW], status_seen[pase_pkg::ST_MISSING_OPERAND],
                 status_seen[pase_pkg::ST_UNMATCHED], status_seen[pase_pkg::ST_EMPTY_PARENS],
                 status_seen[pase_pkg::ST_MISSING_OPERATOR], "missing operator");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
